// ----- hw/rtl/tdp_pkg.sv -----
package tdp_pkg;

  // Width of the tested value.
  localparam int VALUE_BITS = 31;
  // Trial divisor: covers sqrt of the value plus headroom for the last step.
  localparam int DIV_BITS   = (VALUE_BITS + 1) / 2 + 2;
  // Running square of the divisor, with headroom for the 4d+4 update.
  localparam int SQ_BITS    = VALUE_BITS + 4;
  // Bit counter of the serial remainder unit.
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [DIV_BITS-1:0]   div_t;
  typedef logic [SQ_BITS-1:0]    sq_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  typedef struct packed {
    logic start;
    div_t divisor;
  } rem_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } rem_stat_t;

endpackage

// ----- hw/rtl/tdp_rem.sv -----
// Bit-serial restoring remainder: one value bit per cycle, MSB first.
module tdp_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  tdp_pkg::rem_req_t  req,
  input  tdp_pkg::value_t    value,
  output tdp_pkg::rem_stat_t stat
);

  tdp_pkg::value_t shift_r, shift_nxt;
  tdp_pkg::div_t   rem_r, rem_nxt;
  tdp_pkg::div_t   div_r;
  tdp_pkg::cnt_t   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [tdp_pkg::DIV_BITS:0] trial;
  logic [tdp_pkg::DIV_BITS:0] diff;

  assign trial = {rem_r, shift_r[tdp_pkg::VALUE_BITS-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    if (req.start) begin
      shift_nxt = value;
      rem_nxt   = '0;
      cnt_nxt   = tdp_pkg::CNT_BITS'(tdp_pkg::VALUE_BITS);
      busy_nxt  = 1'b1;
    end else if (busy_r) begin
      shift_nxt = {shift_r[tdp_pkg::VALUE_BITS-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = diff[tdp_pkg::DIV_BITS-1:0];
      end else begin
        rem_nxt = trial[tdp_pkg::DIV_BITS-1:0];
      end
      cnt_nxt = cnt_r - tdp_pkg::CNT_BITS'(1);
      if (cnt_r == tdp_pkg::CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    shift_r <= shift_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    if (req.start) begin
      div_r <= req.divisor;
    end
  end

  assign stat.done = done_r;
  assign stat.zero = (rem_r == '0);

endmodule

// ----- hw/rtl/trial_division_prime_test.sv -----
// Trial-division primality test. One value per transfer, one is_prime flag per
// transfer out. 0 and 1 are not prime, 2 and 3 are prime, other even values
// are not prime; these answers are settled in the check state. Odd values
// from 5 up are tried against the odd divisors 3, 5, 7 and so on while
// d*d <= value. Each divisor is tested by the bit-serial remainder unit,
// which walks the value one bit per cycle. A prime takes longest, as it
// runs through every odd divisor up to sqrt(value). One value is in work at
// a time; in_stall is high while it is. The result sits in an output
// register, so the next value is taken while the previous result still waits.
module trial_division_prime_test (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [tdp_pkg::VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_is_prime
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_BOUND,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t             state_r;
  tdp_pkg::value_t    value_r;
  tdp_pkg::div_t      div_r;
  tdp_pkg::sq_t       sq_r;     // div_r squared, kept by running sum
  logic               res_r;
  logic               start_r;
  logic               out_valid_r;
  logic               out_is_prime_r;
  tdp_pkg::rem_req_t  rem_req;
  tdp_pkg::rem_stat_t rem_stat;
  tdp_pkg::sq_t       value_ext;

  assign value_ext = tdp_pkg::SQ_BITS'(value_r);

  assign rem_req.start   = start_r;
  assign rem_req.divisor = div_r;

  tdp_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .value (value_r),
    .stat  (rem_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // one-cycle start pulse when the next divisor is still in bound
      start_r <= (state_r == ST_BOUND) && !(sq_r > value_ext);
      // load a new result, or drop the old one once its transfer completes
      if (state_r == ST_FIN && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else begin
        out_valid_r <= out_valid_r & out_stall;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            value_r <= in_value;
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (value_ext < tdp_pkg::SQ_BITS'(2)) begin
            res_r   <= 1'b0;
            state_r <= ST_FIN;
          end else if (value_ext < tdp_pkg::SQ_BITS'(4)) begin
            res_r   <= 1'b1;
            state_r <= ST_FIN;
          end else if (!value_r[0]) begin
            res_r   <= 1'b0;
            state_r <= ST_FIN;
          end else begin
            div_r   <= tdp_pkg::DIV_BITS'(3);
            sq_r    <= tdp_pkg::SQ_BITS'(9);
            state_r <= ST_BOUND;
          end
        end
        ST_BOUND: begin
          // no divisor up to sqrt(value) found: prime
          if (sq_r > value_ext) begin
            res_r   <= 1'b1;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (rem_stat.done) begin
            if (rem_stat.zero) begin
              res_r   <= 1'b0;
              state_r <= ST_FIN;
            end else begin
              // (d+2)^2 = d^2 + 4d + 4
              div_r   <= div_r + tdp_pkg::DIV_BITS'(2);
              sq_r    <= sq_r + tdp_pkg::SQ_BITS'({div_r, 2'b00})
                         + tdp_pkg::SQ_BITS'(4);
              state_r <= ST_BOUND;
            end
          end
        end
        ST_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_is_prime_r <= res_r;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall     = (state_r != ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

endmodule

// ----- sim/trial_division_prime_test_test.sv -----
`timescale 1ns / 1ps

module trial_division_prime_test_test;

  // Idle chance per cycle, in percent, for both sides.
  localparam int unsigned IDLE_PCT       = 30;
  // Receiver hold-off length for the backpressure test.
  localparam int unsigned HOLD_CYCLES    = 2000;
  // Cycles to watch after the last result, for stray transfers.
  localparam int unsigned TAIL_CYCLES    = 50;
  // Longest quiet stretch is the top value (a prime), which runs the divisor
  // loop to the end. The limit is set well above it before declaring a hang.
  localparam int unsigned WATCHDOG_LIMIT = 4_000_000;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_ITEMS   = 75;
  localparam tdp_pkg::value_t VALUE_MAX  = '1;

  typedef struct {
    tdp_pkg::value_t value;
    logic            is_prime;
  } verdict_t;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  tdp_pkg::value_t in_value  = '0;
  logic            out_stall = 1'b0;
  logic            in_stall;
  logic            out_valid;
  logic            out_is_prime;

  // Verdicts for accepted values, oldest first.
  verdict_t        pending_verdicts[$];
  int unsigned     error_count  = 0;
  // No-idle stretch: both sides run flat out while set.
  logic            calm         = 1'b0;
  // Raised by a test to make the receiver hold off for HOLD_CYCLES.
  logic            hold_request = 1'b0;

  trial_division_prime_test uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_is_prime (out_is_prime)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Plain trial division: 0 and 1 are not prime, 2 and 3 prime,
  // even values above 2 composite, then odd divisors while d*d <= v. The bound
  // is checked as d <= v / d so it cannot overflow.
  function automatic logic prime_by_division(tdp_pkg::value_t v);
    logic [31:0] d;
    if (v < 2) return 1'b0;
    if (v < 4) return 1'b1;
    if (!v[0]) return 1'b0;
    for (d = 3; d <= v / d; d += 2) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Offer one value and hold it until the transfer. Valid is left high on
  // return; the next call or the end of stimulus decides whether it drops,
  // so valid never gets two updates in one step.
  task automatic send_value(input tdp_pkg::value_t v);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_verdicts.push_back('{value: v, is_prime: prime_by_division(v)});
  endtask

  // Trivial answers and a few small primes.
  task automatic test_small_values();
    send_value(0);
    send_value(1);
    send_value(2);
    send_value(3);
    send_value(4);
    send_value(5);
    send_value(97);
    send_value(7919);
  endtask

  // Square bound: composites whose only factor sits right at sqrt(v), and
  // products of neighboring primes.
  task automatic test_square_bound();
    send_value(9);
    send_value(25);
    send_value(49);
    send_value(35);
    send_value(143);
    send_value(63001);  // 251 squared
  endtask

  // Top of the range and alternating bit patterns. The all-ones value is
  // prime, so it runs the divisor loop to the very end.
  task automatic test_wide_values();
    send_value(VALUE_MAX);
    send_value(tdp_pkg::value_t'(VALUE_MAX - 1));
    send_value(tdp_pkg::value_t'(VALUE_MAX - 2));
    send_value(tdp_pkg::value_t'(1) << (tdp_pkg::VALUE_BITS - 1));
    send_value(tdp_pkg::value_t'(32'h5555_5555));
    send_value(tdp_pkg::value_t'(32'h2AAA_AAAA));
  endtask

  // Mostly small values so run time stays bounded; large values are built
  // with a small factor so they finish quickly but still toggle high bits.
  task automatic test_random_values();
    tdp_pkg::value_t v;
    int unsigned     pick;
    int unsigned     f;
    int unsigned     n;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 40 && i < 70);
      pick = $urandom_range(99);
      if (pick < 55) begin
        v = tdp_pkg::value_t'($urandom_range(4095));
      end else if (pick < 65) begin
        v = tdp_pkg::value_t'($urandom_range(1 << 20));
      end else if (pick < 80) begin
        f = 2 * $urandom_range(40, 1) + 1;
        v = tdp_pkg::value_t'(f * $urandom_range(VALUE_MAX / f, 1));
      end else if (pick < 90) begin
        n = $urandom_range(1000, 2);
        v = tdp_pkg::value_t'(n * n);
      end else begin
        v = tdp_pkg::value_t'($urandom) & VALUE_MAX;
        v = tdp_pkg::value_t'(v - (v % 3));
      end
      send_value(v);
    end
    calm = 1'b0;
  endtask

  // Receiver stops for a long stretch while values keep coming: the output
  // register fills, then the block stalls its input.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 6; i++) send_value(tdp_pkg::value_t'($urandom_range(255)));
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_small_values();
    test_square_bound();
    test_wide_values();
    test_output_backpressure();
    test_random_values();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("trial_division_prime_test test passed");
    end else begin
      $display("trial_division_prime_test test failed");
    end
    $finish;
  end

  // Receiver side: random stalls, none in calm stretches, and a counted
  // hold-off on request.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // Each result transfer is matched against the oldest pending verdict.
  initial begin : verdict_checker
    verdict_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && !out_stall) begin
        if (pending_verdicts.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: is_prime=%b", out_is_prime);
        end else begin
          want = pending_verdicts.pop_front();
          if (out_is_prime !== want.is_prime) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("value %0d: is_prime expected %b, got %b",
                       want.value, want.is_prime, out_is_prime);
          end
        end
      end
    end
  end

  // Hang detection: too many cycles in a row without a transfer on either side.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("trial_division_prime_test test failed");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
hw/rtl/tdp_pkg.sv
hw/rtl/tdp_rem.sv
hw/rtl/trial_division_prime_test.sv
sim/trial_division_prime_test_test.sv
